// File: sv/opm_pkg.sv
package opm_pkg;

  // Parameter-table depth: the table index wraps to zero after it reaches this count minus one.
  localparam int TABLE_ENTRIES = 128;

  // Message types
  localparam logic [2:0] MT_READ     = 3'd0;
  localparam logic [2:0] MT_WRITE    = 3'd1;
  localparam logic [2:0] MT_READ_ACK = 3'd4;

  // Pending request codes: 1..15 = poll step + 1, 16..23 = probe number + 16
  localparam logic [4:0] PEND_NONE  = 5'd0;
  localparam logic [4:0] PEND_PROBE = 5'd16;

  // Response status codes
  localparam logic [1:0] ST_SUCCESS = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;

  // Poll cycle steps
  localparam logic [3:0] STEP_MCONFIG = 4'd0;
  localparam logic [3:0] STEP_STATUS  = 4'd1;
  localparam logic [3:0] STEP_LEVEL   = 4'd2;
  localparam logic [3:0] STEP_CONFIG  = 4'd3;
  localparam logic [3:0] STEP_VENT    = 4'd4;
  localparam logic [3:0] STEP_T80     = 4'd5;
  localparam logic [3:0] STEP_T82     = 4'd6;
  localparam logic [3:0] STEP_MVER    = 4'd7;
  localparam logic [3:0] STEP_SVER    = 4'd8;
  localparam logic [3:0] STEP_TABLE   = 4'd9;
  localparam logic [3:0] STEP_FAULT   = 4'd10;
  localparam logic [3:0] STEP_T81     = 4'd11;
  localparam logic [3:0] STEP_T83     = 4'd12;
  localparam logic [3:0] STEP_FAN84   = 4'd13;
  localparam logic [3:0] STEP_FAN85   = 4'd14;
  localparam logic [3:0] STEP_IDLE    = 4'd15;
  localparam logic [3:0] STEP_OPT_FIRST = STEP_T81;

  // Data ids
  localparam logic [7:0] ID_MCONFIG = 8'd2;
  localparam logic [7:0] ID_STATUS  = 8'd70;
  localparam logic [7:0] ID_LEVEL   = 8'd71;
  localparam logic [7:0] ID_FAULT   = 8'd72;
  localparam logic [7:0] ID_CONFIG  = 8'd74;
  localparam logic [7:0] ID_VENT    = 8'd77;
  localparam logic [7:0] ID_OPT78   = 8'd78;
  localparam logic [7:0] ID_OPT79   = 8'd79;
  localparam logic [7:0] ID_T80     = 8'd80;
  localparam logic [7:0] ID_T81     = 8'd81;
  localparam logic [7:0] ID_T82     = 8'd82;
  localparam logic [7:0] ID_T83     = 8'd83;
  localparam logic [7:0] ID_FAN84   = 8'd84;
  localparam logic [7:0] ID_FAN85   = 8'd85;
  localparam logic [7:0] ID_OPT87   = 8'd87;
  localparam logic [7:0] ID_OPT88   = 8'd88;
  localparam logic [7:0] ID_TABLE   = 8'd89;
  localparam logic [7:0] ID_MVER    = 8'd126;
  localparam logic [7:0] ID_SVER    = 8'd127;
  localparam logic [7:0] ID_NONE    = 8'd0;

  // Fixed data words and flags
  localparam logic [15:0] MCONFIG_DATA  = 16'h0012;
  localparam logic [15:0] MVER_DATA     = 16'h1202;
  localparam logic [7:0]  FLAG_VENT_ON  = 8'h01;
  localparam logic [7:0]  FLAG_BYPASS   = 8'h02;
  localparam logic [7:0]  FLAG_FILTER   = 8'h10;
  localparam logic [7:0]  LEVEL_MAX     = 8'd3;
  localparam logic [7:0]  LEVEL_DEFAULT = 8'd2;

  // Update kinds
  localparam logic [3:0] KIND_STATUS  = 4'd0;
  localparam logic [3:0] KIND_VENT    = 4'd1;
  localparam logic [3:0] KIND_T80     = 4'd2;
  localparam logic [3:0] KIND_T81     = 4'd3;
  localparam logic [3:0] KIND_T82     = 4'd4;
  localparam logic [3:0] KIND_T83     = 4'd5;
  localparam logic [3:0] KIND_CONFIG  = 4'd6;
  localparam logic [3:0] KIND_FAULT   = 4'd7;
  localparam logic [3:0] KIND_VERSION = 4'd8;
  localparam logic [3:0] KIND_TABLE   = 4'd9;
  localparam logic [3:0] KIND_FAN84   = 4'd10;
  localparam logic [3:0] KIND_FAN85   = 4'd11;
  localparam logic [3:0] KIND_PROBE   = 4'd12;
  localparam logic [3:0] KIND_LEVEL   = 4'd13;

  // Configuration registers
  localparam logic [1:0]  CFG_VENT_LEVEL = 2'd0;
  localparam logic [1:0]  CFG_BYPASS     = 2'd1;
  localparam logic [1:0]  CFG_TIMEOUT    = 2'd2;
  localparam logic [19:0] TIMEOUT_RESET  = 20'd30000;

  typedef struct packed {
    logic        action;
    logic        filter_reset_request;
    logic [31:0] response_frame;
    logic [1:0]  response_status;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic        request_valid;
    logic [31:0] request_frame;
    logic        update_valid;
    logic [3:0]  update_kind;
    logic [7:0]  update_index;
    logic [15:0] update_value;
    logic        link_connected;
  } out_word_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] kind;
    logic [7:0] index;
    logic [15:0] value;
  } upd_t;

  typedef struct packed {
    upd_t       upd;
    logic       probe_hit;
    logic [2:0] probe_n;
    logic       probe_sup;
  } resp_t;

  // Set bit 31 so the whole frame has even parity.
  function automatic logic [31:0] make_frame(logic [2:0] mtype, logic [7:0] id,
                                             logic [15:0] data);
    logic [31:0] f;
    f = {1'b0, mtype, 4'b0000, id, data};
    f[31] = ^f;
    return f;
  endfunction

  function automatic logic [7:0] probe_id(logic [2:0] n);
    logic [7:0] id;
    case (n)
      3'd0: id = ID_T81;
      3'd1: id = ID_T83;
      3'd2: id = ID_FAN84;
      3'd3: id = ID_FAN85;
      3'd4: id = ID_OPT78;
      3'd5: id = ID_OPT79;
      3'd6: id = ID_OPT87;
      default: id = ID_OPT88;
    endcase
    return id;
  endfunction

  function automatic logic [7:0] poll_id(logic [3:0] s);
    logic [7:0] id;
    case (s)
      STEP_MCONFIG: id = ID_MCONFIG;
      STEP_STATUS:  id = ID_STATUS;
      STEP_LEVEL:   id = ID_LEVEL;
      STEP_CONFIG:  id = ID_CONFIG;
      STEP_VENT:    id = ID_VENT;
      STEP_T80:     id = ID_T80;
      STEP_T82:     id = ID_T82;
      STEP_MVER:    id = ID_MVER;
      STEP_SVER:    id = ID_SVER;
      STEP_TABLE:   id = ID_TABLE;
      STEP_FAULT:   id = ID_FAULT;
      STEP_T81:     id = ID_T81;
      STEP_T83:     id = ID_T83;
      STEP_FAN84:   id = ID_FAN84;
      STEP_FAN85:   id = ID_FAN85;
      default:      id = ID_NONE;
    endcase
    return id;
  endfunction

  // First optional step at or after 'from' whose id is supported, else idle step.
  function automatic logic [3:0] next_optional(logic [3:0] from, logic [3:0] flags);
    logic [3:0] s;
    logic       found;
    s = STEP_IDLE;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!found && flags[i] && (STEP_OPT_FIRST + 4'(i) >= from)) begin
        s = STEP_OPT_FIRST + 4'(i);
        found = 1'b1;
      end
    end
    return s;
  endfunction

endpackage

// File: sv/opm_resp_decode.sv
module opm_resp_decode import opm_pkg::*; (
  input  logic [4:0]  pending,
  input  logic [31:0] frame,
  input  logic        ok,
  output resp_t       resp
);

  logic [3:0] step;
  logic       sup;

  assign step = pending[3:0] - 4'd1;
  assign sup  = ok && (frame[30:28] == MT_READ_ACK);

  always_comb begin
    resp = '0;
    if (pending[4] && !pending[3]) begin
      // probe answer: reported whatever the status
      resp.probe_hit   = 1'b1;
      resp.probe_n     = pending[2:0];
      resp.probe_sup   = sup;
      resp.upd.valid   = 1'b1;
      resp.upd.kind    = KIND_PROBE;
      resp.upd.index   = probe_id(pending[2:0]);
      resp.upd.value   = {15'd0, sup};
    end else if (!pending[4] && (pending != PEND_NONE) && ok) begin
      resp.upd.valid = 1'b1;
      resp.upd.value = frame[15:0];
      case (step)
        STEP_STATUS: begin
          resp.upd.kind  = KIND_STATUS;
          resp.upd.value = {10'd0, frame[13:8]};
        end
        STEP_CONFIG: resp.upd.kind = KIND_CONFIG;
        STEP_VENT: begin
          resp.upd.kind  = KIND_VENT;
          resp.upd.value = {8'd0, frame[15:8]};
        end
        STEP_T80:   resp.upd.kind = KIND_T80;
        STEP_T82:   resp.upd.kind = KIND_T82;
        STEP_SVER:  resp.upd.kind = KIND_VERSION;
        STEP_TABLE: begin
          if ({1'b0, frame[15:8]} < 9'(TABLE_ENTRIES)) begin
            resp.upd.kind  = KIND_TABLE;
            resp.upd.index = frame[15:8];
            resp.upd.value = {8'd0, frame[7:0]};
          end else begin
            resp.upd = '0;
          end
        end
        STEP_FAULT: resp.upd.kind = KIND_FAULT;
        STEP_T81:   resp.upd.kind = KIND_T81;
        STEP_T83:   resp.upd.kind = KIND_T83;
        STEP_FAN84: resp.upd.kind = KIND_FAN84;
        STEP_FAN85: resp.upd.kind = KIND_FAN85;
        default:    resp.upd = '0;  // write steps report nothing
      endcase
    end
  end

endmodule

// File: sv/opentherm_poll_master.sv
// An accepted word waits in the input register until the result register can take its result for out_data.
// Throughput: one word per cycle while out_stall is low; an input register feeds one pass of decode and
// next-state logic into the result register, and each word sees the state left by the last.
// Reset (rst, synchronous, active high): poll step at master config, counters, flags,
// link and pending request cleared; configuration back to level 2, bypass closed,
// timeout 30000 ms; both word registers empty.
module opentherm_poll_master import opm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // item channel
  input  logic       in_valid,
  input  in_word_t   in_data,
  output logic       in_stall,
  // result channel
  output logic       out_valid,
  output out_word_t  out_data,
  input  logic       out_stall,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [19:0] cfg_data
);

  // Handshake registers
  logic      in_valid_q;
  in_word_t  in_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  logic      fire;

  // Configuration
  logic [7:0]  vent_level_request;
  logic        bypass_open;
  logic [19:0] disconnect_timeout_ms;

  // Sequencer state
  logic [3:0]  poll_step, poll_step_next;
  logic [7:0]  table_index, table_index_next;
  logic [2:0]  probe_step, probe_step_next;
  logic        probe_done, probe_done_next;
  logic [7:0]  support_flags, support_flags_next;
  logic        reset_flag_active, reset_flag_active_next;
  logic        reset_request_latched, reset_request_latched_next;
  logic        link_up, link_up_next;
  logic [31:0] last_success_ms, last_success_ms_next;
  logic [4:0]  pending_request, pending_request_next;
  out_word_t   result;

  // Working signals
  logic        ok;
  resp_t       resp;
  logic        latch_eff;
  logic [2:0]  req_type;
  logic [15:0] req_data;
  logic [7:0]  level;
  logic [7:0]  status_flags;
  logic [31:0] since_success;

  // The item in the input register is processed once the result register can take it.
  assign fire      = in_valid_q && (!out_valid_q || !out_stall);
  assign in_stall  = in_valid_q && !fire;
  assign out_valid = out_valid_q;
  assign out_data  = out_word_q;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      in_word_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall) begin
      out_valid_q <= 1'b0;
    end
    if (fire) begin
      out_word_q <= result;
    end
  end

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      vent_level_request    <= LEVEL_DEFAULT;
      bypass_open           <= 1'b0;
      disconnect_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VENT_LEVEL: vent_level_request    <= cfg_data[7:0];
        CFG_BYPASS:     bypass_open           <= cfg_data[0];
        CFG_TIMEOUT:    disconnect_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ok = (in_word_q.response_status == ST_SUCCESS);

  opm_resp_decode u_decode (
    .pending (pending_request),
    .frame   (in_word_q.response_frame),
    .ok      (ok),
    .resp    (resp)
  );

  assign latch_eff     = reset_request_latched | in_word_q.filter_reset_request;
  assign level         = (vent_level_request > LEVEL_MAX) ? LEVEL_DEFAULT : vent_level_request;
  assign since_success = in_word_q.now_ms - last_success_ms;

  always_comb begin
    status_flags = FLAG_VENT_ON;
    if (bypass_open) status_flags = status_flags | FLAG_BYPASS;
    if (reset_flag_active) status_flags = status_flags | FLAG_FILTER;
  end

  always_comb begin
    poll_step_next             = poll_step;
    table_index_next           = table_index;
    probe_step_next            = probe_step;
    probe_done_next            = probe_done;
    support_flags_next         = support_flags;
    reset_flag_active_next     = reset_flag_active;
    reset_request_latched_next = reset_request_latched;
    link_up_next               = link_up;
    last_success_ms_next       = last_success_ms;
    pending_request_next       = pending_request;
    req_type                   = MT_READ;
    req_data                   = '0;
    result                     = '0;

    if (!in_word_q.action) begin
      if (!probe_done && link_up) begin
        // Probe tick: read one optional id; the filter latch holds until a poll tick.
        reset_request_latched_next = latch_eff;
        result.request_valid = 1'b1;
        result.request_frame = make_frame(MT_READ, probe_id(probe_step), 16'd0);
        pending_request_next = PEND_PROBE + {2'b00, probe_step};
        probe_step_next      = probe_step + 3'd1;
        if (probe_step == 3'd7) probe_done_next = 1'b1;
      end else begin
        poll_step_next = poll_step + 4'd1;
        case (poll_step)
          STEP_MCONFIG: begin
            req_type = MT_WRITE;
            req_data = MCONFIG_DATA;
          end
          STEP_STATUS: begin
            req_data = {status_flags, 8'd0};
          end
          STEP_LEVEL: begin
            req_type            = MT_WRITE;
            req_data            = {8'd0, level};
            result.update_valid = 1'b1;
            result.update_kind  = KIND_LEVEL;
            result.update_value = {8'd0, level};
          end
          STEP_MVER: begin
            req_type = MT_WRITE;
            req_data = MVER_DATA;
          end
          STEP_TABLE: begin
            req_data = {table_index, 8'd0};
            if ({1'b0, table_index} + 9'd1 >= 9'(TABLE_ENTRIES)) begin
              table_index_next = '0;
            end else begin
              table_index_next = table_index + 8'd1;
            end
          end
          STEP_FAULT, STEP_T81, STEP_T83, STEP_FAN84, STEP_FAN85: begin
            // skip optional ids the unit does not support
            poll_step_next = next_optional(poll_step + 4'd1, support_flags[3:0]);
          end
          default: ;
        endcase
        if (poll_step == STEP_IDLE) begin
          poll_step_next       = STEP_MCONFIG;
          pending_request_next = PEND_NONE;
        end else begin
          result.request_valid = 1'b1;
          result.request_frame = make_frame(req_type, poll_id(poll_step), req_data);
          pending_request_next = {1'b0, poll_step} + 5'd1;
        end
        // Status step sends the flag and drops it; then the latch moves in.
        if (latch_eff) begin
          reset_request_latched_next = 1'b0;
          reset_flag_active_next     = 1'b1;
        end else if (poll_step == STEP_STATUS) begin
          reset_flag_active_next     = 1'b0;
        end
      end
    end else begin
      // Response: link bookkeeping, then decode against the pending request.
      if (ok) begin
        link_up_next         = 1'b1;
        last_success_ms_next = in_word_q.now_ms;
      end else if (in_word_q.response_status == ST_TIMEOUT && link_up &&
                   since_success > {12'd0, disconnect_timeout_ms}) begin
        link_up_next = 1'b0;
      end
      if (resp.probe_hit) begin
        support_flags_next[resp.probe_n] = resp.probe_sup;
      end
      result.update_valid  = resp.upd.valid;
      result.update_kind   = resp.upd.kind;
      result.update_index  = resp.upd.index;
      result.update_value  = resp.upd.value;
      pending_request_next = PEND_NONE;
    end
    result.link_connected = link_up_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_step             <= STEP_MCONFIG;
      table_index           <= '0;
      probe_step            <= '0;
      probe_done            <= 1'b0;
      support_flags         <= '0;
      reset_flag_active     <= 1'b0;
      reset_request_latched <= 1'b0;
      link_up               <= 1'b0;
      last_success_ms       <= '0;
      pending_request       <= PEND_NONE;
    end else if (fire) begin
      poll_step             <= poll_step_next;
      table_index           <= table_index_next;
      probe_step            <= probe_step_next;
      probe_done            <= probe_done_next;
      support_flags         <= support_flags_next;
      reset_flag_active     <= reset_flag_active_next;
      reset_request_latched <= reset_request_latched_next;
      link_up               <= link_up_next;
      last_success_ms       <= last_success_ms_next;
      pending_request       <= pending_request_next;
    end
  end

endmodule

// File: sv/opm_checker.sv
module opm_checker import opm_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input out_word_t  out_data,
  input logic       out_stall
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_req_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.request_valid |-> out_data.request_frame == 32'd0)
    else $error("request frame not zero without request");

  a_req_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.request_valid |-> !(^out_data.request_frame))
    else $error("request frame parity odd");

  a_both_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.request_valid && out_data.update_valid
      |-> out_data.update_kind == KIND_LEVEL)
    else $error("request with update that is not the level report");

  a_upd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.update_valid
      |-> out_data.update_kind == 4'd0 && out_data.update_index == 8'd0 &&
          out_data.update_value == 16'd0)
    else $error("update fields not zero without update");

endmodule

bind opentherm_poll_master opm_checker u_opm_checker (.*);

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import opm_pkg::*;

  // Item codes not named in the package
  localparam logic       ACT_TICK    = 1'b0;
  localparam logic       ACT_REPLY   = 1'b1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_RESERVED = 2'd3;

  // Hard stop for a hung run, far beyond the slowest legal run
  localparam int LIMIT_NS = 2_000_000;

  // Probe order and poll order, entry 0 on the right
  localparam logic [7:0][7:0] PROBE_IDS = {ID_OPT88, ID_OPT87, ID_OPT79, ID_OPT78,
                                           ID_FAN85, ID_FAN84, ID_T83, ID_T81};
  localparam logic [15:0][7:0] POLL_IDS = {ID_NONE, ID_FAN85, ID_FAN84, ID_T83, ID_T81,
                                           ID_FAULT, ID_TABLE, ID_SVER, ID_MVER, ID_T82,
                                           ID_T80, ID_VENT, ID_CONFIG, ID_LEVEL, ID_STATUS,
                                           ID_MCONFIG};

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t want;
  } stim_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  in_word_t   in_data = '0;
  logic       in_stall;
  logic       out_valid;
  out_word_t  out_data;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;

  // Mirror of the sequencer: settings and state as they stand after reset
  logic [7:0]  set_level = LEVEL_DEFAULT;
  logic        set_bypass = 1'b0;
  logic [19:0] set_timeout = TIMEOUT_RESET;
  logic [3:0]  cur_step = STEP_MCONFIG;
  logic [7:0]  tab_idx = '0;
  logic [2:0]  probe_num = '0;
  logic        probing_over = 1'b0;
  logic [7:0]  opt_support = '0;
  logic        filter_armed = 1'b0;
  logic        filter_latch = 1'b0;
  logic        link_ok = 1'b0;
  logic [31:0] last_ok_ms = '0;
  logic [4:0]  awaiting = PEND_NONE;

  out_word_t   awaited_results[$];
  stim_row_t   directed_rows[$];
  out_word_t   head;
  logic [31:0] clock_ms = '0;
  bit          steady = 1'b0;
  int          failures = 0;

  opentherm_poll_master u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Even parity lands in bit 31 over the other 31 bits.
  function automatic logic [31:0] bus_frame(logic [2:0] mt, logic [7:0] id,
                                            logic [15:0] data);
    logic [30:0] body;
    body = {mt, 4'h0, id, data};
    return {^body, body};
  endfunction

  // Work out the result word for one accepted input word and advance the mirror.
  function automatic out_word_t result_for(in_word_t w);
    out_word_t   r;
    logic [3:0]  s;
    logic [3:0]  nxt;
    logic [2:0]  mt;
    logic [2:0]  n;
    logic [15:0] data;
    logic [7:0]  lvl;
    logic [7:0]  fl;
    logic [31:0] gap_ms;
    logic        ok;
    logic        sup;
    int          k;
    r = '0;
    if (w.action == ACT_TICK) begin
      filter_latch = filter_latch | w.filter_reset_request;
      if (!probing_over && link_ok) begin
        // Probe pass: one optional id per tick; the filter latch is not cleared here
        n = probe_num;
        r.request_valid = 1'b1;
        r.request_frame = bus_frame(MT_READ, PROBE_IDS[n], 16'h0000);
        awaiting = PEND_PROBE + 5'(n);
        if (n == 3'd7) probing_over = 1'b1;
        probe_num = n + 3'd1;
      end else begin
        s = cur_step;
        nxt = s + 4'd1;
        mt = MT_READ;
        data = '0;
        case (s)
          STEP_MCONFIG: begin
            mt = MT_WRITE;
            data = MCONFIG_DATA;
          end
          STEP_STATUS: begin
            fl = FLAG_VENT_ON;
            if (set_bypass) fl = fl | FLAG_BYPASS;
            if (filter_armed) fl = fl | FLAG_FILTER;
            data = {fl, 8'h00};
            filter_armed = 1'b0;
          end
          STEP_LEVEL: begin
            lvl = (set_level > LEVEL_MAX) ? LEVEL_DEFAULT : set_level;
            mt = MT_WRITE;
            data = {8'h00, lvl};
            r.update_valid = 1'b1;
            r.update_kind = KIND_LEVEL;
            r.update_value = {8'h00, lvl};
          end
          STEP_MVER: begin
            mt = MT_WRITE;
            data = MVER_DATA;
          end
          STEP_TABLE: begin
            data = {tab_idx, 8'h00};
            tab_idx = (int'(tab_idx) + 1 >= TABLE_ENTRIES) ? 8'h00 : tab_idx + 8'd1;
          end
          STEP_FAULT, STEP_T81, STEP_T83, STEP_FAN84, STEP_FAN85: begin
            // Skip ahead to the lowest supported optional step past this one
            nxt = STEP_IDLE;
            for (k = 3; k >= 0; k--)
              if (opt_support[k] && int'(STEP_OPT_FIRST) + k > int'(s))
                nxt = STEP_OPT_FIRST + 4'(k);
          end
          default: ;
        endcase
        if (s == STEP_IDLE) begin
          nxt = STEP_MCONFIG;
          awaiting = PEND_NONE;
        end else begin
          r.request_valid = 1'b1;
          r.request_frame = bus_frame(mt, POLL_IDS[s], data);
          awaiting = {1'b0, s} + 5'd1;
        end
        cur_step = nxt;
        if (filter_latch) begin
          filter_latch = 1'b0;
          filter_armed = 1'b1;
        end
      end
    end else begin
      ok = (w.response_status == ST_SUCCESS);
      gap_ms = w.now_ms - last_ok_ms;
      if (ok) begin
        link_ok = 1'b1;
        last_ok_ms = w.now_ms;
      end else if (w.response_status == ST_TIMEOUT && link_ok && gap_ms > 32'(set_timeout)) begin
        link_ok = 1'b0;
      end
      if (awaiting >= PEND_PROBE) begin
        // Probe answers report whatever the status
        n = awaiting[2:0];
        sup = ok && (w.response_frame[30:28] == MT_READ_ACK);
        opt_support[n] = sup;
        r.update_valid = 1'b1;
        r.update_kind = KIND_PROBE;
        r.update_index = PROBE_IDS[n];
        r.update_value = {15'h0000, sup};
      end else if (awaiting != PEND_NONE && ok) begin
        s = 4'(awaiting - 5'd1);
        r.update_valid = 1'b1;
        r.update_value = w.response_frame[15:0];
        case (s)
          STEP_STATUS: begin
            r.update_kind = KIND_STATUS;
            r.update_value = {10'h000, w.response_frame[13:8]};
          end
          STEP_CONFIG: r.update_kind = KIND_CONFIG;
          STEP_VENT: begin
            r.update_kind = KIND_VENT;
            r.update_value = {8'h00, w.response_frame[15:8]};
          end
          STEP_T80:  r.update_kind = KIND_T80;
          STEP_T82:  r.update_kind = KIND_T82;
          STEP_SVER: r.update_kind = KIND_VERSION;
          STEP_TABLE: begin
            if (w.response_frame[15:8] < TABLE_ENTRIES) begin
              r.update_kind = KIND_TABLE;
              r.update_index = w.response_frame[15:8];
              r.update_value = {8'h00, w.response_frame[7:0]};
            end else begin
              r.update_valid = 1'b0;
              r.update_value = '0;
            end
          end
          STEP_FAULT: r.update_kind = KIND_FAULT;
          STEP_T81:   r.update_kind = KIND_T81;
          STEP_T83:   r.update_kind = KIND_T83;
          STEP_FAN84: r.update_kind = KIND_FAN84;
          STEP_FAN85: r.update_kind = KIND_FAN85;
          default: begin
            // Write steps answer with nothing to report
            r.update_valid = 1'b0;
            r.update_value = '0;
          end
        endcase
      end
      awaiting = PEND_NONE;
    end
    r.link_connected = link_ok;
    return r;
  endfunction

  // Tick words carry junk in the reply-only fields; the block must ignore it.
  function automatic in_word_t tick_word(logic filt);
    in_word_t w;
    w = '0;
    w.action = ACT_TICK;
    w.filter_reset_request = filt;
    w.response_frame = $urandom;
    w.response_status = 2'($urandom);
    w.now_ms = $urandom;
    return w;
  endfunction

  function automatic in_word_t reply_word(logic [31:0] frame, logic [1:0] st,
                                          logic [31:0] now);
    in_word_t w;
    w = '0;
    w.action = ACT_REPLY;
    w.filter_reset_request = 1'($urandom);
    w.response_frame = frame;
    w.response_status = st;
    w.now_ms = now;
    return w;
  endfunction

  // Mostly read-acks, a spread of failure codes, and clock jumps that straddle
  // the disconnect threshold.
  function automatic in_word_t random_reply();
    logic [31:0] frame;
    logic [1:0]  st;
    int          roll;
    frame = $urandom;
    if ($urandom_range(4) != 0) frame[30:28] = MT_READ_ACK;
    roll = $urandom_range(99);
    st = (roll < 72) ? ST_SUCCESS : (roll < 84) ? ST_TIMEOUT :
         (roll < 94) ? ST_INVALID : ST_RESERVED;
    roll = $urandom_range(99);
    if (roll < 80) clock_ms = clock_ms + $urandom_range(3000);
    else if (roll < 92) clock_ms = last_ok_ms + 32'(set_timeout) + $urandom_range(1);
    else if (roll < 97) clock_ms = clock_ms + $urandom_range(2 * int'(set_timeout) + 1);
    else clock_ms = $urandom;
    return reply_word(frame, st, clock_ms);
  endfunction

  function automatic out_word_t plain_result(logic rv, logic [31:0] rf, logic uv,
                                             logic [3:0] kind, logic [15:0] val,
                                             logic link);
    out_word_t r;
    r = '0;
    r.request_valid = rv;
    r.request_frame = rf;
    r.update_valid = uv;
    r.update_kind = kind;
    r.update_value = val;
    r.link_connected = link;
    return r;
  endfunction

  function automatic stim_row_t row(in_word_t w, logic typed, out_word_t want);
    stim_row_t r;
    r.w = w;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Offer one word, hold it through stalls, and queue its result once taken.
  // A typed row queues the value written in the table instead of the mirror's.
  task automatic push_word(in_word_t w, logic typed, out_word_t want);
    out_word_t got;
    while (!steady && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = result_for(w);
    awaited_results.push_back(typed ? want : got);
  endtask

  // Drop valid, drain every awaited result, then let the pipe sit idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leave cfg_valid high between writes; the caller drops it after the last.
  task automatic write_setting(logic [1:0] idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_VENT_LEVEL: set_level = val[7:0];
      CFG_BYPASS:     set_bypass = val[0];
      CFG_TIMEOUT:    set_timeout = val;
      default: ;
    endcase
  endtask

  // Upper bits of the narrow registers get junk; only the low bits count.
  task automatic apply_settings(logic [7:0] lvl, logic byp, logic [19:0] tmo);
    write_setting(CFG_VENT_LEVEL, {12'($urandom), lvl});
    write_setting(CFG_BYPASS, {19'($urandom), byp});
    write_setting(CFG_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
  endtask

  // Ticks each followed by a reply in reply_pct percent of cases; the rest are lost replies
  // (the next tick replaces the pending request), plus occasional extra replies that may
  // find nothing pending.
  task automatic run_traffic(int count, int reply_pct);
    for (int i = 0; i < count; i++) begin
      push_word(tick_word($urandom_range(7) == 0), 1'b0, '0);
      if ($urandom_range(99) < reply_pct) push_word(random_reply(), 1'b0, '0);
      if ($urandom_range(99) < 4) push_word(random_reply(), 1'b0, '0);
    end
  endtask

  // Stall the result side at random except during the steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 21);
  end

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
      failures++;
    end
  endtask

  // Compare each taken result word with the oldest awaited one.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, out_data);
        failures++;
      end else begin
        head = awaited_results.pop_front();
        check_field("request_valid", 32'(head.request_valid), 32'(out_data.request_valid));
        check_field("request_frame", head.request_frame, out_data.request_frame);
        check_field("update_valid", 32'(head.update_valid), 32'(out_data.update_valid));
        check_field("update_kind", 32'(head.update_kind), 32'(out_data.update_kind));
        check_field("update_index", 32'(head.update_index), 32'(out_data.update_index));
        check_field("update_value", 32'(head.update_value), 32'(out_data.update_value));
        check_field("link_connected", 32'(head.link_connected),
                    32'(out_data.link_connected));
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    // Stray reply before any tick, all ones: nothing pending, link stays down
    directed_rows.push_back(row(reply_word(32'hFFFF_FFFF, ST_INVALID, 32'hFFFF_FFFF), 1'b1,
                                plain_result(1'b0, '0, 1'b0, '0, '0, 1'b0)));
    // First poll cycle with the link down; the filter request arms the status flag
    directed_rows.push_back(row(tick_word(1'b1), 1'b1,
                                plain_result(1'b1, 32'h1002_0012, 1'b0, '0, '0, 1'b0)));
    directed_rows.push_back(row(tick_word(1'b0), 1'b1,
                                plain_result(1'b1, 32'h8046_1100, 1'b0, '0, '0, 1'b0)));
    directed_rows.push_back(row(tick_word(1'b0), 1'b1,
                                plain_result(1'b1, 32'h1047_0002, 1'b1, KIND_LEVEL, 16'd2,
                                             1'b0)));
    // Ack of a write step: link comes up, nothing decoded
    directed_rows.push_back(row(reply_word(32'h5047_0002, ST_SUCCESS, 32'd1000), 1'b1,
                                plain_result(1'b0, '0, 1'b0, '0, '0, 1'b1)));
    // Probe pass: supported, wrong type, timeout at the threshold, supported,
    // reserved status, lost reply, supported, invalid
    directed_rows.push_back(row(tick_word(1'b0), 1'b0, '0));
    directed_rows.push_back(row(reply_word(32'h4051_0000, ST_SUCCESS, 32'd2000), 1'b0, '0));
    directed_rows.push_back(row(tick_word(1'b1), 1'b0, '0));
    directed_rows.push_back(row(reply_word(32'h0053_0000, ST_SUCCESS, 32'd3000), 1'b0, '0));
    directed_rows.push_back(row(tick_word(1'b0), 1'b0, '0));
    directed_rows.push_back(row(reply_word(32'h4054_0000, ST_TIMEOUT, 32'd33000), 1'b0, '0));
    directed_rows.push_back(row(tick_word(1'b0), 1'b0, '0));
    directed_rows.push_back(row(reply_word(32'hC055_0000, ST_SUCCESS, 32'd4000), 1'b0, '0));
    directed_rows.push_back(row(tick_word(1'b0), 1'b0, '0));
    directed_rows.push_back(row(reply_word(32'h404E_0000, ST_RESERVED, 32'd4500), 1'b0, '0));
    directed_rows.push_back(row(tick_word(1'b0), 1'b0, '0));
    directed_rows.push_back(row(tick_word(1'b0), 1'b0, '0));
    directed_rows.push_back(row(reply_word(32'h4057_0000, ST_SUCCESS, 32'd5000), 1'b0, '0));
    directed_rows.push_back(row(tick_word(1'b0), 1'b0, '0));
    directed_rows.push_back(row(reply_word(32'h4058_0000, ST_INVALID, 32'd5000), 1'b0, '0));
    // Back to polling at the config read; the latched filter request moves on
    directed_rows.push_back(row(tick_word(1'b0), 1'b0, '0));
    directed_rows.push_back(row(reply_word(32'h404A_5A5A, ST_SUCCESS, 32'd40000), 1'b0, '0));
    // Timeout one past the threshold drops the link
    directed_rows.push_back(row(reply_word(32'h0000_0000, ST_TIMEOUT, 32'd70001), 1'b1,
                                plain_result(1'b0, '0, 1'b0, '0, '0, 1'b0)));
    directed_rows.push_back(row(tick_word(1'b0), 1'b0, '0));
    directed_rows.push_back(row(reply_word(32'h404D_80FF, ST_SUCCESS, 32'hFFFF_FFFF), 1'b0, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table at the reset settings
    foreach (directed_rows[i]) push_word(directed_rows[i].w, directed_rows[i].typed,
                                         directed_rows[i].want);
    settle();

    // Lowest level, bypass open, zero timeout
    apply_settings(8'd0, 1'b1, 20'd0);
    run_traffic(150, 88);
    settle();

    // Highest level, timeout of 1000000 ms; a long steady stretch of mostly bare ticks
    apply_settings(8'd255, 1'b0, 20'd1000000);
    steady = 1'b1;
    run_traffic(700, 12);
    settle();
    steady = 1'b0;

    // Level at the clamp edge, random timeout, clock about to wrap
    clock_ms = 32'hFFFF_F000;
    apply_settings(8'd3, 1'b1, 20'($urandom_range(999999, 1)));
    run_traffic(120, 88);
    settle();

    // Just above the clamp, timeout back to its reset value
    apply_settings(8'd4, 1'b0, TIMEOUT_RESET);
    run_traffic(120, 88);
    settle();

    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
